[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is low
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Same, with a message of the caller's choosing
`define ASSERT_AT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

[design/iprhf_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 receive header filter package
// Transaction types, verdict and protocol codes, and header byte positions.
// ----------------------------------------------------------------------------
package iprhf_pkg;

    // Width of the saturating received-byte counter
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Width used when comparing header length against received length
    localparam int LEN_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // Header byte positions
    localparam logic [COUNT_BITS-1:0] POS_VER_IHL  = COUNT_BITS'(0);
    localparam logic [COUNT_BITS-1:0] POS_TLEN_HI  = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] POS_TLEN_LO  = COUNT_BITS'(3);
    localparam logic [COUNT_BITS-1:0] POS_PROTO    = COUNT_BITS'(9);
    localparam logic [COUNT_BITS-1:0] POS_SRC_0    = COUNT_BITS'(12);
    localparam logic [COUNT_BITS-1:0] POS_SRC_1    = COUNT_BITS'(13);
    localparam logic [COUNT_BITS-1:0] POS_SRC_2    = COUNT_BITS'(14);
    localparam logic [COUNT_BITS-1:0] POS_SRC_3    = COUNT_BITS'(15);
    localparam logic [COUNT_BITS-1:0] POS_DST_0    = COUNT_BITS'(16);
    localparam logic [COUNT_BITS-1:0] POS_DST_1    = COUNT_BITS'(17);
    localparam logic [COUNT_BITS-1:0] POS_DST_2    = COUNT_BITS'(18);
    localparam logic [COUNT_BITS-1:0] POS_DST_3    = COUNT_BITS'(19);

    // Minimum datagram length and expected version
    localparam logic [COUNT_BITS-1:0] MIN_HEADER_BYTES = COUNT_BITS'(20);
    localparam logic [3:0]            IPV4_VERSION     = 4'd4;

    // Protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT      = 3'd0,
        VERDICT_TOO_SHORT   = 3'd1,
        VERDICT_BAD_VERSION = 3'd2,
        VERDICT_SHORT_IHL   = 3'd3,
        VERDICT_OTHER_DEST  = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        CLASS_ICMP  = 2'd0,
        CLASS_UDP   = 2'd1,
        CLASS_TCP   = 2'd2,
        CLASS_OTHER = 2'd3
    } t_proto_class;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_verdict     verdict;
        t_proto_class protocol_class;
        logic [7:0]   protocol_number;
        logic [31:0]  sender_ip;
        logic [5:0]   payload_offset;
        logic [15:0]  payload_length;
    } t_out_item;

endpackage

[design/ipv4_receive_header_filter_top.sv]
// ----------------------------------------------------------------------------
// IPv4 receive header filter
// Captures IPv4 header fields from a byte stream and gives one verdict per
// datagram on its last byte.
// ----------------------------------------------------------------------------
// The block takes one datagram byte per cycle while not stalled, with no gap
// needed between datagrams. Each byte updates a saturating byte count and
// the header field registers; the last byte also produces the verdict, which
// is registered in the output register or, while that is stalled, the skid
// stage. A two-entry output (register plus skid stage) lets input continue
// while a verdict waits; input stall rises only once both entries hold
// verdicts. No clearing pass is needed after reset. The local address is
// written through the configuration channel, which is always ready.
module ipv4_receive_header_filter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_data,
    // byte input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  iprhf_pkg::t_in_item  i_in_data,
    // verdict output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output iprhf_pkg::t_out_item o_out_data
);

    localparam int CB = iprhf_pkg::COUNT_BITS;
    localparam int LB = iprhf_pkg::LEN_BITS;

    // Configuration and per-datagram state
    logic [31:0]   r_local_ip;
    logic [CB-1:0] r_byte_count, n_byte_count;
    logic [7:0]    r_ver_ihl, n_ver_ihl;
    logic [15:0]   r_ip_length, n_ip_length;
    logic [7:0]    r_proto, n_proto;
    logic [31:0]   r_src, n_src;
    logic [31:0]   r_dst, n_dst;

    // Output register and skid stage
    logic                 r_out_valid;
    iprhf_pkg::t_out_item r_out;
    logic                 r_skid_valid;
    iprhf_pkg::t_out_item r_skid;
    iprhf_pkg::t_out_item n_result;

    logic          in_accept;
    logic          produce;
    logic          out_free;
    logic [5:0]    ihl_bytes;
    logic [CB-1:0] avail;
    logic [15:0]   tlen_diff;
    logic [LB-1:0] len_clip;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign produce   = in_accept && i_in_data.last_byte;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Capture header bytes at their positions and advance the count
    always_comb begin
        n_ver_ihl   = r_ver_ihl;
        n_ip_length = r_ip_length;
        n_proto     = r_proto;
        n_src       = r_src;
        n_dst       = r_dst;
        case (r_byte_count)
            iprhf_pkg::POS_VER_IHL: n_ver_ihl         = i_in_data.data_byte;
            iprhf_pkg::POS_TLEN_HI: n_ip_length[15:8] = i_in_data.data_byte;
            iprhf_pkg::POS_TLEN_LO: n_ip_length[7:0]  = i_in_data.data_byte;
            iprhf_pkg::POS_PROTO:   n_proto           = i_in_data.data_byte;
            iprhf_pkg::POS_SRC_0:   n_src[31:24]      = i_in_data.data_byte;
            iprhf_pkg::POS_SRC_1:   n_src[23:16]      = i_in_data.data_byte;
            iprhf_pkg::POS_SRC_2:   n_src[15:8]       = i_in_data.data_byte;
            iprhf_pkg::POS_SRC_3:   n_src[7:0]        = i_in_data.data_byte;
            iprhf_pkg::POS_DST_0:   n_dst[31:24]      = i_in_data.data_byte;
            iprhf_pkg::POS_DST_1:   n_dst[23:16]      = i_in_data.data_byte;
            iprhf_pkg::POS_DST_2:   n_dst[15:8]       = i_in_data.data_byte;
            iprhf_pkg::POS_DST_3:   n_dst[7:0]        = i_in_data.data_byte;
            default: ;
        endcase
        n_byte_count = (r_byte_count == iprhf_pkg::COUNT_MAX) ?
                       r_byte_count : r_byte_count + CB'(1);
    end

    // Work out the verdict from the updated fields
    always_comb begin
        ihl_bytes = {n_ver_ihl[3:0], 2'b00};
        avail     = n_byte_count - CB'(ihl_bytes);
        tlen_diff = (n_ip_length > 16'(ihl_bytes)) ? n_ip_length - 16'(ihl_bytes) : 16'd0;
        len_clip  = (LB'(tlen_diff) > LB'(avail)) ? LB'(avail) : LB'(tlen_diff);

        n_result                 = '0;
        n_result.verdict         = iprhf_pkg::VERDICT_ACCEPT;
        n_result.protocol_class  = iprhf_pkg::CLASS_ICMP;
        if (n_byte_count < iprhf_pkg::MIN_HEADER_BYTES) begin
            n_result.verdict = iprhf_pkg::VERDICT_TOO_SHORT;
        end else if (n_ver_ihl[7:4] != iprhf_pkg::IPV4_VERSION) begin
            n_result.verdict = iprhf_pkg::VERDICT_BAD_VERSION;
        end else if (n_byte_count < CB'(ihl_bytes)) begin
            n_result.verdict = iprhf_pkg::VERDICT_SHORT_IHL;
        end else if (n_dst != r_local_ip) begin
            n_result.verdict = iprhf_pkg::VERDICT_OTHER_DEST;
        end else begin
            n_result.protocol_number = n_proto;
            n_result.sender_ip       = n_src;
            n_result.payload_offset  = ihl_bytes;
            n_result.payload_length  = 16'(len_clip);
            case (n_proto)
                iprhf_pkg::PROTO_ICMP: n_result.protocol_class = iprhf_pkg::CLASS_ICMP;
                iprhf_pkg::PROTO_UDP:  n_result.protocol_class = iprhf_pkg::CLASS_UDP;
                iprhf_pkg::PROTO_TCP:  n_result.protocol_class = iprhf_pkg::CLASS_TCP;
                default:               n_result.protocol_class = iprhf_pkg::CLASS_OTHER;
            endcase
        end
    end

    // Hold the local address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_local_ip <= i_cfg_data;
        end
    end

    // Advance header state; drop it all at the end of a datagram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || produce) begin
            r_byte_count <= '0;
            r_ver_ihl    <= '0;
            r_ip_length  <= '0;
            r_proto      <= '0;
            r_src        <= '0;
            r_dst        <= '0;
        end else if (in_accept) begin
            r_byte_count <= n_byte_count;
            r_ver_ihl    <= n_ver_ihl;
            r_ip_length  <= n_ip_length;
            r_proto      <= n_proto;
            r_src        <= n_src;
            r_dst        <= n_dst;
        end
    end

    // Output register with skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (produce) begin
                r_out <= n_result;
            end
        end else if (produce) begin
            r_skid <= n_result;
        end
    end

endmodule

[design/iprhf_checker.sv]
// ----------------------------------------------------------------------------
// IPv4 receive header filter checker
// Port-level assertions on the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iprhf_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input iprhf_pkg::t_out_item o_out_data
);

    // A stalled verdict transaction stays and holds its payload
    `ASSERT_AT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)
    `ASSERT_AT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_out_data))

    // Rejected datagrams carry no header detail
    `ASSERT_AT_MSG(a_reject_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.verdict != iprhf_pkg::VERDICT_ACCEPT |->
        o_out_data.sender_ip == 32'd0 && o_out_data.payload_length == 16'd0 &&
        o_out_data.payload_offset == 6'd0 && o_out_data.protocol_number == 8'd0,
        "rejected verdict with non-zero fields")

    // On accept: ICMP/TCP class matches protocol number; offset multiple of 4
    `ASSERT_AT_MSG(a_class_match, i_clk, i_rst_n,
        o_out_valid && o_out_data.verdict == iprhf_pkg::VERDICT_ACCEPT |->
        ((o_out_data.protocol_class == iprhf_pkg::CLASS_ICMP) ==
         (o_out_data.protocol_number == iprhf_pkg::PROTO_ICMP)) &&
        ((o_out_data.protocol_class == iprhf_pkg::CLASS_TCP) ==
         (o_out_data.protocol_number == iprhf_pkg::PROTO_TCP)) &&
        o_out_data.payload_offset[1:0] == 2'b00,
        "protocol class or offset inconsistent")

    // Input stalls only after a verdict sat stalled at the output
    `ASSERT_AT_MSG(a_stall_cause, i_clk, i_rst_n,
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall),
        "input stall without a waiting verdict")

endmodule

bind ipv4_receive_header_filter_top iprhf_checker u_iprhf_checker (.*);

[bench/tb_ipv4_receive_header_filter_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv4 receive header filter testbench
// Streams directed and random datagrams into the filter one byte per
// transaction, predicts the verdict of each datagram from captured header
// fields, and compares every verdict transaction field by field.
// ----------------------------------------------------------------------------
module tb_ipv4_receive_header_filter_top;

    localparam int          CB              = iprhf_pkg::COUNT_BITS;
    localparam logic [31:0] LOCAL_A         = 32'hC0A8_0107;
    localparam logic [31:0] OTHER_A         = 32'hC0A8_0108;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          HOLD_CYCLES     = 200;
    localparam int          PHASE_BYTES     = 50;
    localparam int          PHASE_DATAGRAMS = 3;

    // One datagram to send; typed rows carry their verdict, others are predicted
    typedef struct packed {
        logic [7:0]          ver_ihl;
        logic [15:0]         ip_length;
        logic [7:0]          proto;
        logic [31:0]         src;
        logic [31:0]         dst;
        logic [16:0]         nbytes;
        logic                typed;
        iprhf_pkg::t_verdict verdict;
    } t_probe;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [31:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    iprhf_pkg::t_in_item  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    iprhf_pkg::t_out_item o_out_data;

    // Header capture state of the bench predictor
    logic [CB-1:0] seen_bytes    = '0;
    logic [7:0]    cap_ver_ihl   = '0;
    logic [15:0]   cap_ip_length = '0;
    logic [7:0]    cap_proto     = '0;
    logic [31:0]   cap_src       = '0;
    logic [31:0]   cap_dst       = '0;
    logic [31:0]   our_ip        = '0;

    iprhf_pkg::t_out_item pending_verdicts [$];
    int        mismatch_count = 0;
    int        tx_idle_pct    = 0;
    int        rx_idle_pct    = 0;
    int        hold_requests  = 0;
    int        hold_served    = 0;
    int        hold_left      = 0;
    int        phase_bytes    = 0;

    // Directed datagrams: ver_ihl, total length, protocol, source, destination,
    // bytes received, typed, verdict
    t_probe probe_table [16] = '{
        '{8'h45, 16'd20, iprhf_pkg::PROTO_UDP, 32'h0A00_0001, LOCAL_A, 17'd1, 1'b1,
          iprhf_pkg::VERDICT_TOO_SHORT},
        '{8'h45, 16'd20, iprhf_pkg::PROTO_UDP, 32'h0A00_0001, LOCAL_A, 17'd19, 1'b1,
          iprhf_pkg::VERDICT_TOO_SHORT},
        '{8'h65, 16'd40, iprhf_pkg::PROTO_TCP, 32'h0A00_0002, LOCAL_A, 17'd20, 1'b1,
          iprhf_pkg::VERDICT_BAD_VERSION},
        '{8'h00, 16'd0, 8'h00, 32'h0000_0000, 32'h0000_0000, 17'd20, 1'b1,
          iprhf_pkg::VERDICT_BAD_VERSION},
        '{8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd20, 1'b1,
          iprhf_pkg::VERDICT_BAD_VERSION},
        '{8'h4F, 16'd60, iprhf_pkg::PROTO_TCP, 32'h0A00_0003, LOCAL_A, 17'd20, 1'b1,
          iprhf_pkg::VERDICT_SHORT_IHL},
        '{8'h46, 16'd24, iprhf_pkg::PROTO_TCP, 32'h0A00_0003, LOCAL_A, 17'd23, 1'b1,
          iprhf_pkg::VERDICT_SHORT_IHL},
        '{8'h45, 16'd28, iprhf_pkg::PROTO_ICMP, 32'h0A00_0004, OTHER_A, 17'd20, 1'b1,
          iprhf_pkg::VERDICT_OTHER_DEST},
        '{8'h45, 16'd28, iprhf_pkg::PROTO_ICMP, 32'h0A00_0001, LOCAL_A, 17'd28, 1'b0,
          iprhf_pkg::VERDICT_ACCEPT},
        '{8'h45, 16'd40, iprhf_pkg::PROTO_UDP, 32'hFFFF_FFFF, LOCAL_A, 17'd30, 1'b0,
          iprhf_pkg::VERDICT_ACCEPT},
        '{8'h45, 16'd20, iprhf_pkg::PROTO_TCP, 32'h0000_0000, LOCAL_A, 17'd24, 1'b0,
          iprhf_pkg::VERDICT_ACCEPT},
        '{8'h46, 16'd10, 8'hFF, 32'h8000_0001, LOCAL_A, 17'd26, 1'b0,
          iprhf_pkg::VERDICT_ACCEPT},
        '{8'h4F, 16'hFFFF, 8'h00, 32'h0102_0304, LOCAL_A, 17'd60, 1'b0,
          iprhf_pkg::VERDICT_ACCEPT},
        '{8'h40, 16'd10, iprhf_pkg::PROTO_UDP, 32'hA5A5_5A5A, LOCAL_A, 17'd20, 1'b0,
          iprhf_pkg::VERDICT_ACCEPT},
        '{8'h41, 16'd0, iprhf_pkg::PROTO_TCP, 32'h5A5A_A5A5, LOCAL_A, 17'd21, 1'b0,
          iprhf_pkg::VERDICT_ACCEPT},
        '{8'h45, 16'hFFFF, iprhf_pkg::PROTO_UDP, 32'h7F00_0001, LOCAL_A, 17'd20, 1'b0,
          iprhf_pkg::VERDICT_ACCEPT}
    };

    ipv4_receive_header_filter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Capture one accepted byte and work out the verdict on the last one
    task automatic absorb_byte(input logic [7:0] b, input logic last,
                               output bit due, output iprhf_pkg::t_out_item v);
        int ihl_bytes;
        int avail;
        int paylen;
        due = 1'b0;
        v   = '0;
        case (seen_bytes)
            iprhf_pkg::POS_VER_IHL: cap_ver_ihl         = b;
            iprhf_pkg::POS_TLEN_HI: cap_ip_length[15:8] = b;
            iprhf_pkg::POS_TLEN_LO: cap_ip_length[7:0]  = b;
            iprhf_pkg::POS_PROTO:   cap_proto           = b;
            iprhf_pkg::POS_SRC_0:   cap_src[31:24]      = b;
            iprhf_pkg::POS_SRC_1:   cap_src[23:16]      = b;
            iprhf_pkg::POS_SRC_2:   cap_src[15:8]       = b;
            iprhf_pkg::POS_SRC_3:   cap_src[7:0]        = b;
            iprhf_pkg::POS_DST_0:   cap_dst[31:24]      = b;
            iprhf_pkg::POS_DST_1:   cap_dst[23:16]      = b;
            iprhf_pkg::POS_DST_2:   cap_dst[15:8]       = b;
            iprhf_pkg::POS_DST_3:   cap_dst[7:0]        = b;
            default: ;
        endcase
        // Saturate the byte count
        if (seen_bytes != iprhf_pkg::COUNT_MAX) seen_bytes++;
        if (last) begin
            due       = 1'b1;
            ihl_bytes = int'(cap_ver_ihl[3:0]) * 4;
            if (seen_bytes < iprhf_pkg::MIN_HEADER_BYTES) begin
                v.verdict = iprhf_pkg::VERDICT_TOO_SHORT;
            end else if (cap_ver_ihl[7:4] != iprhf_pkg::IPV4_VERSION) begin
                v.verdict = iprhf_pkg::VERDICT_BAD_VERSION;
            end else if (int'(seen_bytes) < ihl_bytes) begin
                v.verdict = iprhf_pkg::VERDICT_SHORT_IHL;
            end else if (cap_dst != our_ip) begin
                v.verdict = iprhf_pkg::VERDICT_OTHER_DEST;
            end else begin
                // Clip the payload to what actually arrived
                avail  = int'(seen_bytes) - ihl_bytes;
                paylen = (int'(cap_ip_length) > ihl_bytes) ?
                         int'(cap_ip_length) - ihl_bytes : 0;
                if (paylen > avail) paylen = avail;
                v.verdict         = iprhf_pkg::VERDICT_ACCEPT;
                v.protocol_number = cap_proto;
                case (cap_proto)
                    iprhf_pkg::PROTO_ICMP: v.protocol_class = iprhf_pkg::CLASS_ICMP;
                    iprhf_pkg::PROTO_UDP:  v.protocol_class = iprhf_pkg::CLASS_UDP;
                    iprhf_pkg::PROTO_TCP:  v.protocol_class = iprhf_pkg::CLASS_TCP;
                    default:               v.protocol_class = iprhf_pkg::CLASS_OTHER;
                endcase
                v.sender_ip      = cap_src;
                v.payload_offset = 6'(ihl_bytes);
                v.payload_length = 16'(paylen);
            end
            // Start afresh for the next datagram
            seen_bytes    = '0;
            cap_ver_ihl   = '0;
            cap_ip_length = '0;
            cap_proto     = '0;
            cap_src       = '0;
            cap_dst       = '0;
        end
    endtask

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last,
                             output bit due, output iprhf_pkg::t_out_item v);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, last_byte: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        absorb_byte(b, last, due, v);
        phase_bytes++;
    endtask

    // Send a whole datagram and queue its verdict
    task automatic send_datagram(input t_probe p);
        logic [7:0]           b;
        logic [CB-1:0]        pos;
        bit                   due;
        iprhf_pkg::t_out_item v;
        iprhf_pkg::t_out_item typed_v;
        for (int i = 0; i < int'(p.nbytes); i++) begin
            pos = CB'(i);
            case (pos)
                iprhf_pkg::POS_VER_IHL: b = p.ver_ihl;
                iprhf_pkg::POS_TLEN_HI: b = p.ip_length[15:8];
                iprhf_pkg::POS_TLEN_LO: b = p.ip_length[7:0];
                iprhf_pkg::POS_PROTO:   b = p.proto;
                iprhf_pkg::POS_SRC_0, iprhf_pkg::POS_SRC_1,
                iprhf_pkg::POS_SRC_2, iprhf_pkg::POS_SRC_3:
                    b = p.src[8*(iprhf_pkg::POS_SRC_3-pos) +: 8];
                iprhf_pkg::POS_DST_0, iprhf_pkg::POS_DST_1,
                iprhf_pkg::POS_DST_2, iprhf_pkg::POS_DST_3:
                    b = p.dst[8*(iprhf_pkg::POS_DST_3-pos) +: 8];
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == int'(p.nbytes) - 1, due, v);
            if (due) begin
                if (p.typed) begin
                    typed_v         = '0;
                    typed_v.verdict = p.verdict;
                    pending_verdicts.push_back(typed_v);
                end else begin
                    pending_verdicts.push_back(v);
                end
            end
        end
    endtask

    // Mostly well-formed datagrams with random content, the rest noise
    function automatic t_probe random_datagram();
        t_probe p;
        int     ihl;
        int     hdr;
        int     body;
        p     = '0;
        p.src = $urandom;
        if ($urandom_range(99) < 70) begin
            ihl       = ($urandom_range(99) < 85) ? 5 : int'($urandom_range(15));
            hdr       = ihl * 4;
            body      = (hdr > 20) ? hdr : 20;
            p.ver_ihl = {iprhf_pkg::IPV4_VERSION, 4'(ihl)};
            case ($urandom_range(3))
                0:       p.proto = iprhf_pkg::PROTO_ICMP;
                1:       p.proto = iprhf_pkg::PROTO_UDP;
                2:       p.proto = iprhf_pkg::PROTO_TCP;
                default: p.proto = 8'($urandom);
            endcase
            p.ip_length = ($urandom_range(9) == 0) ? 16'($urandom) :
                          16'(hdr + $urandom_range(24));
            if ($urandom_range(1) == 0 && int'(p.ip_length) >= 20 && p.ip_length <= 40)
                p.nbytes = 17'(p.ip_length);
            else
                p.nbytes = 17'($urandom_range(body + 8, 20));
            case ($urandom_range(9))
                0:       p.dst = $urandom;
                1:       p.dst = our_ip ^ (32'h1 << $urandom_range(31));
                default: p.dst = our_ip;
            endcase
        end else begin
            p.ver_ihl   = 8'($urandom);
            p.ip_length = 16'($urandom);
            p.proto     = 8'($urandom);
            p.dst       = $urandom_range(1) ? our_ip : $urandom;
            p.nbytes    = 17'($urandom_range(30, 1));
        end
        return p;
    endfunction

    // Write the local address register
    task automatic write_our_ip(input logic [31:0] addr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        our_ip = addr;
    endtask

    // Drop valid, wait for every verdict, then let the pipeline go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input bit with_hold_off);
        int     datagrams = 0;
        t_probe p;
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES || datagrams < PHASE_DATAGRAMS) begin
            if (with_hold_off && datagrams == 1) begin
                // Ask for a long receiver hold and keep short datagrams coming
                hold_requests++;
                repeat (8) begin
                    p        = random_datagram();
                    p.nbytes = 17'($urandom_range(3, 1));
                    send_datagram(p);
                    datagrams++;
                end
            end else begin
                send_datagram(random_datagram());
                datagrams++;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Verdict sink: check each transaction, then decide the next stall
    always @(posedge i_clk) begin : verdict_sink
        iprhf_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: verdict with none expected, expected none, got %h",
                             $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("verdict", 32'(want.verdict), 32'(o_out_data.verdict));
                    check_field("protocol_class", 32'(want.protocol_class),
                                32'(o_out_data.protocol_class));
                    check_field("protocol_number", 32'(want.protocol_number),
                                32'(o_out_data.protocol_number));
                    check_field("sender_ip", want.sender_ip, o_out_data.sender_ip);
                    check_field("payload_offset", 32'(want.payload_offset),
                                32'(o_out_data.payload_offset));
                    check_field("payload_length", 32'(want.payload_length),
                                32'(o_out_data.payload_length));
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left   = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        tx_idle_pct = 27;
        rx_idle_pct = 51;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_our_ip(LOCAL_A);
        foreach (probe_table[k]) send_datagram(probe_table[k]);
        settle();

        write_our_ip(32'h0000_0000);
        run_random_phase(1'b0);
        settle();

        tx_idle_pct = 51;
        rx_idle_pct = 27;
        write_our_ip(32'hFFFF_FFFF);
        run_random_phase(1'b1);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_our_ip($urandom);
        run_random_phase(1'b0);
        settle();

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Timeout
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
